@@ rtl/tlb_lookup_insert_invalidate_assert.svh @@
// Assertion macros used by the translation buffer controller.
// Each use is sampled on i_clk and disabled while i_rst_n is low.
`ifndef TLB_LOOKUP_INSERT_INVALIDATE_ASSERT_SVH
`define TLB_LOOKUP_INSERT_INVALIDATE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define TLB_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("translation buffer check failed");

// Consequent must hold in the cycle after the antecedent
`define TLB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("translation buffer check failed");

`endif

@@ rtl/tlb_pkg.sv @@
package tlb_pkg;

    // Fixed field widths of the request and result
    localparam int REQ_W    = 2;
    localparam int PAGE_W   = 8;
    localparam int RIGHTS_W = 2;
    localparam int FRAME_W  = 7;

    // Default configuration
    localparam int ENTRIES_DEF   = 32;
    localparam int PAGE_BITS_DEF = 8;

    // Request kinds
    typedef enum logic [REQ_W-1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_INVAL  = 2'd2,
        REQ_FLUSH  = 2'd3
    } t_req;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture the input transfer
        logic match;   // register tag compare and free vectors
        logic encode;  // register priority-encoded indexes
        logic read;    // read rights and frame of the matching entry
        logic exec;    // update the table and load the result
    } t_cmd;

endpackage

@@ rtl/tlb_ctrl.sv @@
module tlb_ctrl
    import tlb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    output logic o_valid,
    input  logic i_ready,
    output t_cmd o_cmd
);

`include "tlb_lookup_insert_invalidate_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_ENC,
        S_READ,
        S_EXEC
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   w_accept;
    logic   w_go;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign w_accept = i_valid && o_ready;
    // Finish only once the output register is free or being emptied
    assign w_go     = (r_state == S_EXEC) && (!r_out_valid || i_ready);

    // Issue one command per step
    always_comb begin
        o_cmd        = '0;
        o_cmd.load   = w_accept;
        o_cmd.match  = (r_state == S_MATCH);
        o_cmd.encode = (r_state == S_ENC);
        o_cmd.read   = (r_state == S_READ);
        o_cmd.exec   = w_go;
    end

    // Advance through the steps of one request
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept) n_state = S_MATCH;
            S_MATCH: n_state = S_ENC;
            S_ENC:   n_state = S_READ;
            S_READ:  n_state = S_EXEC;
            S_EXEC:  if (w_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Hold the result valid until its transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (w_go) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `TLB_ASSERT_NOW(a_one_cmd, 1'b1,
        $onehot0({o_cmd.load, o_cmd.match, o_cmd.encode, o_cmd.read, o_cmd.exec}))
    `TLB_ASSERT_NEXT(a_accept_starts, w_accept, r_state == S_MATCH)
    `TLB_ASSERT_NEXT(a_result_held, r_out_valid && !i_ready, r_out_valid)
    `TLB_ASSERT_NEXT(a_exec_gives_result, o_cmd.exec, r_out_valid && r_state == S_IDLE)

endmodule

@@ rtl/tlb_dp.sv @@
module tlb_dp
    import tlb_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [PAGE_W-1:0]   i_page_number,
    input  logic [RIGHTS_W-1:0] i_access_rights,
    input  logic [FRAME_W-1:0]  i_frame_in,
    output logic                o_hit,
    output logic [FRAME_W-1:0]  o_frame_out,
    output logic                o_table_full
);

    localparam int TAG_W  = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int DATA_W = RIGHTS_W + FRAME_W;

    // Captured request
    t_req                r_req;
    logic [TAG_W-1:0]    r_page;
    logic [RIGHTS_W-1:0] r_rights;
    logic [FRAME_W-1:0]  r_frame;

    // Tags and valid bits in flops for the parallel compare
    logic [ENTRIES-1:0]  r_valid;
    logic [TAG_W-1:0]    r_tag [ENTRIES];

    // Rights and frame in a memory
    logic [DATA_W-1:0]   r_mem [ENTRIES];
    logic [DATA_W-1:0]   r_rd_data;

    logic [ENTRIES-1:0]  r_match_vec;
    logic [ENTRIES-1:0]  r_free_vec;
    logic [IDX_W-1:0]    w_m_idx;
    logic                w_m_any;
    logic [IDX_W-1:0]    w_f_idx;
    logic                w_f_any;
    logic [IDX_W-1:0]    r_m_idx;
    logic                r_m_any;
    logic [IDX_W-1:0]    r_f_idx;
    logic                r_f_any;

    logic                w_ins;
    logic                w_fill;
    logic                w_wr_en;
    logic [IDX_W-1:0]    w_wr_addr;

    logic                r_hit;
    logic [FRAME_W-1:0]  r_frame_out;
    logic                r_full;
    logic                n_hit;
    logic [FRAME_W-1:0]  n_frame_out;
    logic                n_full;

    // Capture the request on its transfer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req    <= t_req'(i_req_type);
            r_page   <= i_page_number[TAG_W-1:0];
            r_rights <= i_access_rights;
            r_frame  <= i_frame_in;
        end
    end

    // Compare the page against every tag
    always_ff @(posedge i_clk) begin
        if (i_cmd.match) begin
            for (int i = 0; i < ENTRIES; i++) begin
                r_match_vec[i] <= r_valid[i] && (r_tag[i] == r_page);
            end
            r_free_vec <= ~r_valid;
        end
    end

    // Find the lowest matching and the lowest free entry
    always_comb begin
        w_m_idx = '0;
        w_m_any = 1'b0;
        w_f_idx = '0;
        w_f_any = 1'b0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_match_vec[i]) begin
                w_m_idx = IDX_W'(i);
                w_m_any = 1'b1;
            end
            if (r_free_vec[i]) begin
                w_f_idx = IDX_W'(i);
                w_f_any = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.encode) begin
            r_m_idx <= w_m_idx;
            r_m_any <= w_m_any;
            r_f_idx <= w_f_idx;
            r_f_any <= w_f_any;
        end
    end

    // Insert updates the match in place, else fills the lowest free entry
    assign w_ins     = i_cmd.exec && (r_req == REQ_INSERT);
    assign w_fill    = w_ins && !r_m_any && r_f_any;
    assign w_wr_en   = w_ins && (r_m_any || r_f_any);
    assign w_wr_addr = r_m_any ? r_m_idx : r_f_idx;

    // Write and read the rights and frame memory
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= {r_rights, r_frame};
        end
        if (i_cmd.read) begin
            r_rd_data <= r_mem[r_m_idx];
        end
    end

    // Write the tag of a newly filled entry
    always_ff @(posedge i_clk) begin
        if (w_fill) begin
            r_tag[r_f_idx] <= r_page;
        end
    end

    // Set, clear or flush valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_cmd.exec) begin
            case (r_req)
                REQ_INSERT: if (!r_m_any && r_f_any) r_valid[r_f_idx] <= 1'b1;
                REQ_INVAL:  if (r_m_any) r_valid[r_m_idx] <= 1'b0;
                REQ_FLUSH:  r_valid <= '0;
                default:    r_valid <= r_valid;
            endcase
        end
    end

    // Form the result of the current request
    always_comb begin
        n_hit       = 1'b0;
        n_frame_out = '0;
        n_full      = 1'b0;
        case (r_req)
            REQ_LOOKUP: begin
                if (r_m_any && (r_rd_data[FRAME_W +: RIGHTS_W] >= r_rights)) begin
                    n_hit       = 1'b1;
                    n_frame_out = r_rd_data[FRAME_W-1:0];
                end
            end
            REQ_INSERT: n_full = !r_m_any && !r_f_any;
            default:    n_full = 1'b0;
        endcase
    end

    // Load the result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_hit       <= n_hit;
            r_frame_out <= n_frame_out;
            r_full      <= n_full;
        end
    end

    assign o_hit        = r_hit;
    assign o_frame_out  = r_frame_out;
    assign o_table_full = r_full;

endmodule

@@ rtl/tlb_lookup_insert_invalidate.sv @@
// Fully associative translation buffer with lookup, insert, invalidate and
// flush requests. Each request runs through these steps before the next
// input transfer is accepted: capture, a parallel compare of the page
// against all tags, a priority encode of the match and free vectors, a
// registered read of the rights/frame memory, and the table update with the
// result load. The result sits in an output register; a stalled result holds
// the block in its final step. Lookup hits on the lowest valid matching
// entry only if its rights code is at least the requested one. Insert
// rewrites a match or fills the lowest free entry; on a full table it is
// dropped and o_table_full is set. Reset clears all valid bits at once.
module tlb_lookup_insert_invalidate
    import tlb_pkg::*;
#(
    parameter int ENTRIES   = ENTRIES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [REQ_W-1:0]    i_req_type,
    input  logic [PAGE_W-1:0]   i_page_number,
    input  logic [RIGHTS_W-1:0] i_access_rights,
    input  logic [FRAME_W-1:0]  i_frame_in,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_hit,
    output logic [FRAME_W-1:0]  o_frame_out,
    output logic                o_table_full
);

    t_cmd w_cmd;

    // Sequence the steps of each request
    tlb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (w_cmd)
    );

    // Hold the table and compute results
    tlb_dp #(
        .ENTRIES   (ENTRIES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_req_type      (i_req_type),
        .i_page_number   (i_page_number),
        .i_access_rights (i_access_rights),
        .i_frame_in      (i_frame_in),
        .o_hit           (o_hit),
        .o_frame_out     (o_frame_out),
        .o_table_full    (o_table_full)
    );

endmodule
